/* sv/cfp_pkg.sv */
// Shared types and constants of the checksummed frame parser.
package cfp_pkg;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_PARSED     = 2'd1,
    ST_HDR_ERR    = 2'd2,
    ST_DATA_ERR   = 2'd3
  } status_e;

  localparam logic [7:0] SYNC_FIRST  = 8'd10;
  localparam logic [7:0] SYNC_SECOND = 8'd60;

  // header byte positions; HDR_DONE marks a completed header
  localparam logic [2:0] HDR_SYNC0  = 3'd0;
  localparam logic [2:0] HDR_SYNC1  = 3'd1;
  localparam logic [2:0] HDR_ACK    = 3'd2;
  localparam logic [2:0] HDR_SEQ    = 3'd3;
  localparam logic [2:0] HDR_LEN    = 3'd4;
  localparam logic [2:0] HDR_CHK_LO = 3'd5;
  localparam logic [2:0] HDR_CHK_HI = 3'd6;
  localparam logic [2:0] HDR_DONE   = 3'd7;

  localparam int unsigned ACK_ERR_BIT = 7;

endpackage

/* sv/cfp_stream_if.sv */
// Valid/ready channel interfaces for received bytes and parse results.
interface cfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_res_if;
  logic                valid;
  logic                ready;
  cfp_pkg::status_e    status;
  logic                payload_valid;
  logic [7:0]          payload_byte;
  logic [7:0]          payload_offset;
  logic [6:0]          ack_index;
  logic                ack_error;
  logic [7:0]          frame_sequence;
  logic [7:0]          frame_length;

  modport source (output valid, output status, output payload_valid, output payload_byte,
                  output payload_offset, output ack_index, output ack_error,
                  output frame_sequence, output frame_length, input ready);
  modport sink   (input valid, input status, input payload_valid, input payload_byte,
                  input payload_offset, input ack_index, input ack_error,
                  input frame_sequence, input frame_length, output ready);
endinterface

/* sv/checksummed_frame_parser_top.sv */
// Checksummed frame parser: per-byte header/payload recognition with Fletcher checks.
// Each accepted byte's result is registered in the output register.
// Throughput: one byte per cycle while the output register can take it; the per-byte work is one
// compare and two 8-bit adds feeding the parser state and the result register.
// Input ready follows the output register: free or being drained in the same cycle.
// Reset (asynchronous, active low) returns the parser to header byte 0 with empty sums.
module checksummed_frame_parser_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfp_rx_if.sink    in_i,
  cfp_res_if.source out_o
);
  import cfp_pkg::*;

  logic [2:0] hdr_pos_q, hdr_pos_d;
  logic [8:0] pay_pos_q, pay_pos_d;
  logic [7:0] hsum_lo_q, hsum_lo_d, hsum_hi_q, hsum_hi_d;
  logic [7:0] psum_lo_q, psum_lo_d, psum_hi_q, psum_hi_d;
  logic [7:0] ack_q, ack_d;
  logic [7:0] seq_q, seq_d;
  logic [7:0] len_q, len_d;

  logic       out_valid_q;
  status_e    status_q, status_d;
  logic       pv_q, pv_d;
  logic [7:0] pbyte_q, pbyte_d;
  logic [7:0] poff_q, poff_d;
  logic [6:0] ack_idx_q, ack_idx_d;
  logic       ack_err_q, ack_err_d;
  logic [7:0] fseq_q, fseq_d;
  logic [7:0] flen_q, flen_d;

  logic       accept;
  logic       restart;
  logic [7:0] b;
  logic [7:0] hlo_add, plo_add;
  logic       hdr_bad, hdr_add;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.rx_byte;
  assign hlo_add    = hsum_lo_q + b;
  assign plo_add    = psum_lo_q + b;

  always_comb begin
    hdr_pos_d = hdr_pos_q;
    pay_pos_d = pay_pos_q;
    hsum_lo_d = hsum_lo_q;
    hsum_hi_d = hsum_hi_q;
    psum_lo_d = psum_lo_q;
    psum_hi_d = psum_hi_q;
    ack_d     = ack_q;
    seq_d     = seq_q;
    len_d     = len_q;
    restart   = 1'b0;
    hdr_bad   = 1'b0;
    hdr_add   = 1'b1;

    status_d  = ST_INCOMPLETE;
    pv_d      = 1'b0;
    pbyte_d   = '0;
    poff_d    = '0;
    ack_idx_d = '0;
    ack_err_d = 1'b0;
    fseq_d    = '0;
    flen_d    = '0;

    if (hdr_pos_q != HDR_DONE) begin
      case (hdr_pos_q)
        HDR_SYNC0:  hdr_bad = (b != SYNC_FIRST);
        HDR_SYNC1:  hdr_bad = (b != SYNC_SECOND);
        HDR_ACK:    ack_d = b;
        HDR_SEQ:    seq_d = b;
        HDR_LEN:    len_d = b;
        HDR_CHK_LO: begin
          hdr_bad = (b != hsum_lo_q);
          hdr_add = 1'b0;
        end
        default: begin
          hdr_bad = (b != hsum_hi_q);
          hdr_add = 1'b0;
        end
      endcase
      if (hdr_bad) begin
        status_d = ST_HDR_ERR;
        restart  = 1'b1;
      end else begin
        if (hdr_add) begin
          hsum_lo_d = hlo_add;
          hsum_hi_d = hsum_hi_q + hlo_add;
        end
        hdr_pos_d = hdr_pos_q + 3'd1;
      end
    end else if (pay_pos_q < {1'b0, len_q}) begin
      pv_d      = 1'b1;
      pbyte_d   = b;
      poff_d    = pay_pos_q[7:0];
      psum_lo_d = plo_add;
      psum_hi_d = psum_hi_q + plo_add;
      pay_pos_d = pay_pos_q + 9'd1;
    end else if (pay_pos_q == {1'b0, len_q}) begin
      if (b != psum_lo_q) begin
        status_d = ST_DATA_ERR;
        restart  = 1'b1;
      end else begin
        pay_pos_d = pay_pos_q + 9'd1;
      end
    end else begin
      restart = 1'b1;
      if (b != psum_hi_q) begin
        status_d = ST_DATA_ERR;
      end else begin
        status_d  = ST_PARSED;
        ack_idx_d = ack_q[6:0];
        ack_err_d = ack_q[ACK_ERR_BIT];
        fseq_d    = seq_q;
        flen_d    = len_q;
      end
    end

    // sequence and length bytes are always rewritten before use, so left as is
    if (restart) begin
      hdr_pos_d = HDR_SYNC0;
      pay_pos_d = '0;
      hsum_lo_d = '0;
      hsum_hi_d = '0;
      psum_lo_d = '0;
      psum_hi_d = '0;
      ack_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q   <= HDR_SYNC0;
      pay_pos_q   <= '0;
      hsum_lo_q   <= '0;
      hsum_hi_q   <= '0;
      psum_lo_q   <= '0;
      psum_hi_q   <= '0;
      ack_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        hdr_pos_q <= hdr_pos_d;
        pay_pos_q <= pay_pos_d;
        hsum_lo_q <= hsum_lo_d;
        hsum_hi_q <= hsum_hi_d;
        psum_lo_q <= psum_lo_d;
        psum_hi_q <= psum_hi_d;
        ack_q     <= ack_d;
      end
      if (in_i.ready) begin
        out_valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q     <= seq_d;
      len_q     <= len_d;
      status_q  <= status_d;
      pv_q      <= pv_d;
      pbyte_q   <= pbyte_d;
      poff_q    <= poff_d;
      ack_idx_q <= ack_idx_d;
      ack_err_q <= ack_err_d;
      fseq_q    <= fseq_d;
      flen_q    <= flen_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.payload_valid  = pv_q;
  assign out_o.payload_byte   = pbyte_q;
  assign out_o.payload_offset = poff_q;
  assign out_o.ack_index      = ack_idx_q;
  assign out_o.ack_error      = ack_err_q;
  assign out_o.frame_sequence = fseq_q;
  assign out_o.frame_length   = flen_q;

`ifndef SYNTHESIS
  // payload position only advances once the header is complete
  a_pay_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_pos_q != HDR_DONE) |-> (pay_pos_q == '0))
    else $error("payload position moved during header");

  // never more than the two check bytes past the payload
  a_pay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_pos_q == HDR_DONE) |-> (pay_pos_q <= ({1'b0, len_q} + 9'd1)))
    else $error("payload position past check bytes");

  // a payload byte transaction never carries a final status
  a_pay_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pv_q) |-> (status_q == ST_INCOMPLETE))
    else $error("payload byte with final status");

  // any final status restarts the parser at header byte 0
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (status_d != ST_INCOMPLETE)) |=>
      (hdr_pos_q == HDR_SYNC0 && psum_lo_q == '0 && hsum_lo_q == '0))
    else $error("parser did not restart after frame end");
`endif

endmodule

/* test/frame_parse_checker.sv */
// Frame parser checker: predicts each per-byte result and compares it with the block's output.
module frame_parse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfp_rx_if           rx_mon,
  cfp_res_if          res_mon,
  output int unsigned mismatches_o,
  output int unsigned results_due_o,
  output int unsigned parsed_o,
  output int unsigned hdr_errs_o,
  output int unsigned data_errs_o,
  output int unsigned payload_bytes_o
);
  import cfp_pkg::*;

  typedef struct packed {
    status_e    status;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_offset;
    logic [6:0] ack_index;
    logic       ack_error;
    logic [7:0] frame_sequence;
    logic [7:0] frame_length;
  } parse_result_t;

  // parser state mirror
  logic [2:0] hdr_pos;
  logic [8:0] pay_pos;
  logic [7:0] hdr_lo, hdr_hi, pay_lo, pay_hi;
  logic [7:0] ack_q, seq_q, len_q;

  parse_result_t parse_results_due[$];

  initial begin
    mismatches_o    = 0;
    results_due_o   = 0;
    parsed_o        = 0;
    hdr_errs_o      = 0;
    data_errs_o     = 0;
    payload_bytes_o = 0;
  end

  function automatic void clear_parser();
    hdr_pos = HDR_SYNC0;
    pay_pos = '0;
    hdr_lo  = '0;
    hdr_hi  = '0;
    pay_lo  = '0;
    pay_hi  = '0;
    ack_q   = '0;
    seq_q   = '0;
    len_q   = '0;
  endfunction

  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t r;
    logic          bad;
    logic          add;
    r        = '0;
    r.status = ST_INCOMPLETE;
    bad      = 1'b0;
    add      = 1'b1;
    if (hdr_pos != HDR_DONE) begin
      case (hdr_pos)
        HDR_SYNC0: bad = (b != SYNC_FIRST);
        HDR_SYNC1: bad = (b != SYNC_SECOND);
        HDR_ACK: ack_q = b;
        HDR_SEQ: seq_q = b;
        HDR_LEN: len_q = b;
        HDR_CHK_LO: begin
          bad = (b != hdr_lo);
          add = 1'b0;
        end
        default: begin
          bad = (b != hdr_hi);
          add = 1'b0;
        end
      endcase
      if (bad) begin
        clear_parser();
        r.status = ST_HDR_ERR;
      end else begin
        if (add) begin
          hdr_lo = hdr_lo + b;
          hdr_hi = hdr_hi + hdr_lo;
        end
        hdr_pos = hdr_pos + 3'd1;
      end
    end else if (pay_pos < {1'b0, len_q}) begin
      r.payload_valid  = 1'b1;
      r.payload_byte   = b;
      r.payload_offset = pay_pos[7:0];
      pay_lo  = pay_lo + b;
      pay_hi  = pay_hi + pay_lo;
      pay_pos = pay_pos + 9'd1;
    end else if (pay_pos == {1'b0, len_q}) begin
      if (b != pay_lo) begin
        clear_parser();
        r.status = ST_DATA_ERR;
      end else begin
        pay_pos = pay_pos + 9'd1;
      end
    end else begin
      // second payload check byte ends the frame either way
      if (b != pay_hi) begin
        r.status = ST_DATA_ERR;
      end else begin
        r.status         = ST_PARSED;
        r.ack_index      = ack_q[ACK_ERR_BIT-1:0];
        r.ack_error      = ack_q[ACK_ERR_BIT];
        r.frame_sequence = seq_q;
        r.frame_length   = len_q;
      end
      clear_parser();
    end
    return r;
  endfunction

  function automatic string show(input parse_result_t r);
    return $sformatf("st=%s pv=%0b pb=%02h off=%0d ack=%0d err=%0b seq=%02h len=%0d",
                     r.status.name(), r.payload_valid, r.payload_byte, r.payload_offset,
                     r.ack_index, r.ack_error, r.frame_sequence, r.frame_length);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t got;
    parse_result_t want;
    if (!rst_ni) begin
      clear_parser();
      parse_results_due.delete();
      results_due_o = 0;
    end else begin
      // drain side first: a result never belongs to a byte taken on the same edge
      if (res_mon.valid && res_mon.ready) begin
        got.status         = res_mon.status;
        got.payload_valid  = res_mon.payload_valid;
        got.payload_byte   = res_mon.payload_byte;
        got.payload_offset = res_mon.payload_offset;
        got.ack_index      = res_mon.ack_index;
        got.ack_error      = res_mon.ack_error;
        got.frame_sequence = res_mon.frame_sequence;
        got.frame_length   = res_mon.frame_length;
        if (parse_results_due.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("[%0t] unexpected result: %s", $realtime, show(got));
        end else begin
          want = parse_results_due.pop_front();
          if (got.status !== want.status || got.payload_valid !== want.payload_valid ||
              got.payload_byte !== want.payload_byte ||
              got.payload_offset !== want.payload_offset ||
              got.ack_index !== want.ack_index || got.ack_error !== want.ack_error ||
              got.frame_sequence !== want.frame_sequence ||
              got.frame_length !== want.frame_length) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
          case (want.status)
            ST_PARSED:   parsed_o++;
            ST_HDR_ERR:  hdr_errs_o++;
            ST_DATA_ERR: data_errs_o++;
            default:     ;
          endcase
          if (want.payload_valid) payload_bytes_o++;
        end
      end
      if (rx_mon.valid && rx_mon.ready)
        parse_results_due.push_back(parse_byte(rx_mon.rx_byte));
      results_due_o = parse_results_due.size();
    end
  end

endmodule

/* test/tb_checksummed_frame_parser_top.sv */
// Testbench top for the checksummed frame parser: stimulus, receiver stalls and verdict.
module tb_checksummed_frame_parser_top;
  import cfp_pkg::*;

  localparam int unsigned BYTE_TARGET = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_LIMIT  = 5000;

  logic clk_i;
  logic rst_ni;

  cfp_rx_if  rx_if();
  cfp_res_if res_if();

  int unsigned mismatches;
  int unsigned results_due;
  int unsigned parsed_cnt;
  int unsigned hdr_err_cnt;
  int unsigned data_err_cnt;
  int unsigned payload_cnt;

  int unsigned bytes_sent;
  int unsigned holds_done;
  int unsigned idle_cycles;
  bit          hold_request;
  bit          steady_mode;
  logic [7:0]  tx_bytes[$];

  checksummed_frame_parser_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (rx_if),
    .out_o (res_if)
  );

  frame_parse_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_mon         (rx_if),
    .res_mon        (res_if),
    .mismatches_o   (mismatches),
    .results_due_o  (results_due),
    .parsed_o       (parsed_cnt),
    .hdr_errs_o     (hdr_err_cnt),
    .data_errs_o    (data_err_cnt),
    .payload_bytes_o(payload_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly short payloads, a few full-size ones
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 6);
    if (r < 97) return $urandom_range(7, 32);
    return 255;
  endfunction

  // builds one frame with correct checks; flip_idx >= 0 corrupts that byte,
  // keep >= 0 truncates the frame to that many bytes
  task automatic push_frame(input logic [7:0] ack, input logic [7:0] seq,
                            input logic [7:0] len, input int flip_idx, input int keep);
    logic [7:0] f[$];
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] b;
    f  = {SYNC_FIRST, SYNC_SECOND, ack, seq, len};
    lo = '0;
    hi = '0;
    foreach (f[i]) begin
      lo = lo + f[i];
      hi = hi + lo;
    end
    f.push_back(lo);
    f.push_back(hi);
    lo = '0;
    hi = '0;
    for (int i = 0; i < len; i++) begin
      b  = 8'($urandom);
      lo = lo + b;
      hi = hi + lo;
      f.push_back(b);
    end
    f.push_back(lo);
    f.push_back(hi);
    if (flip_idx >= 0 && flip_idx < f.size())
      f[flip_idx] = f[flip_idx] ^ 8'($urandom_range(1, 255));
    if (keep >= 0)
      while (f.size() > keep) void'(f.pop_back());
    foreach (f[i]) tx_bytes.push_back(f[i]);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (!steady_mode && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    bytes_sent++;
    if (bytes_sent == 400 || bytes_sent == 1400) hold_request = 1'b1;
  endtask

  task automatic send_all();
    steady_mode = ($urandom_range(0, 3) == 0);
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  // stimulus
  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned fsize;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    rst_ni        = 1'b0;
    bytes_sent    = 0;
    hold_request  = 1'b0;
    steady_mode   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: sync errors, header check error, empty frame, payload check error
    tx_bytes.push_back(8'hff);
    tx_bytes.push_back(SYNC_FIRST);
    tx_bytes.push_back(8'h00);
    push_frame(8'h3c, 8'h81, 8'd0, 6, 7);
    push_frame(8'hff, 8'h00, 8'd0, -1, -1);
    push_frame(8'h00, 8'hff, 8'd1, 9, -1);
    send_all();

    // random: one full-size frame, then mostly good frames with broken ones and noise
    push_frame(8'($urandom), 8'($urandom), 8'd255, -1, -1);
    send_all();
    while (bytes_sent < BYTE_TARGET) begin
      kind  = $urandom_range(0, 99);
      len   = pick_length();
      fsize = len + 9;
      if (kind < 70) begin
        push_frame(8'($urandom), 8'($urandom), 8'(len), -1, -1);
      end else if (kind < 88) begin
        push_frame(8'($urandom), 8'($urandom), 8'(len), $urandom_range(0, fsize - 1), -1);
      end else if (kind < 93) begin
        push_frame(8'($urandom), 8'($urandom), 8'(len), -1, $urandom_range(1, fsize - 1));
      end else begin
        repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom));
      end
      send_all();
    end
    rx_if.valid <= 1'b0;

    // let the checker see the last accepted byte before looking at the count
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("Sent %0d bytes with %0d long receiver hold-offs; %0d payload bytes passed out.",
             bytes_sent, holds_done, payload_cnt);
    $display("Frames parsed: %0d, header errors: %0d, payload check errors: %0d.",
             parsed_cnt, hdr_err_cnt, data_err_cnt);
    if (mismatches == 0 && results_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result receiver: random ready bursts and gaps, plus long hold-offs on request
  initial begin
    res_if.ready = 1'b0;
    holds_done   = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
        holds_done++;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 9) < 7) repeat ($urandom_range(1, 8)) @(posedge clk_i);
        else repeat ($urandom_range(30, 150)) @(posedge clk_i);
        res_if.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
